/* hdl/htfd_pkg.sv */
package htfd_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned FIFO_DEPTH = 2;

    // register indexes, byte address is 4 * index
    localparam logic REG_CRC_CHECK = 1'b0;
    localparam logic REG_ENABLE    = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BUSY     = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR  = 2'd2;
    localparam logic [1:0] STATUS_DISABLED = 2'd3;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [2:0] LAST_BYTE_IDX = 3'd6;

    localparam logic [13:0] HUM_SCALE  = 14'd10000;
    localparam logic [14:0] TEMP_SCALE = 15'd20000;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd5000;

    localparam int unsigned TDATA_W = 72;

    typedef struct packed {
        logic crc_check_enable;
        logic block_enabled;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] hum_raw;
        logic [19:0] temp_raw;
    } frame_rec_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/htfd_front.sv */
module htfd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  htfd_pkg::cfg_t      cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // rx_byte
    input  logic [0:0]          s_tuser,   // frame_start
    input  logic                fifo_full,
    output logic                push,
    output htfd_pkg::frame_rec_t push_rec
);
    import htfd_pkg::*;

    logic [2:0]  count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic        busy_reg, busy_next;
    logic [19:0] hum_reg, hum_next;
    logic [19:0] temp_reg, temp_next;

    logic        accept;
    logic [2:0]  eff_count;
    logic [7:0]  eff_crc;
    logic        last_byte;

    assign s_tready  = !fifo_full;
    assign accept    = s_tvalid && s_tready;
    // a frame start restarts the count and the crc before this byte goes in
    assign eff_count = s_tuser[0] ? 3'd0 : count_reg;
    assign eff_crc   = s_tuser[0] ? CRC_INIT : crc_reg;
    assign last_byte = (eff_count == LAST_BYTE_IDX);

    always_comb begin
        count_next = count_reg;
        crc_next   = crc_reg;
        busy_next  = busy_reg;
        hum_next   = hum_reg;
        temp_next  = temp_reg;
        if (accept) begin
            unique case (eff_count)
                3'd0: busy_next = s_tdata[7];
                3'd1: hum_next = {s_tdata, 12'd0};
                3'd2: hum_next = hum_reg | {8'd0, s_tdata, 4'd0};
                3'd3: begin
                    hum_next  = hum_reg | {16'd0, s_tdata[7:4]};
                    temp_next = {s_tdata[3:0], 16'd0};
                end
                3'd4: temp_next = temp_reg | {4'd0, s_tdata, 8'd0};
                3'd5: temp_next = temp_reg | {12'd0, s_tdata};
                default: ;
            endcase
            if (last_byte) begin
                count_next = 3'd0;
                crc_next   = CRC_INIT;
            end else begin
                count_next = eff_count + 3'd1;
                crc_next   = crc8_byte(eff_crc, s_tdata);
            end
        end
    end

    always_comb begin
        push_rec.hum_raw  = hum_reg;
        push_rec.temp_raw = temp_reg;
        priority if (!cfg.block_enabled) begin
            push_rec.status = STATUS_DISABLED;
        end else if (busy_reg) begin
            push_rec.status = STATUS_BUSY;
        end else if (cfg.crc_check_enable && (eff_crc != s_tdata)) begin
            push_rec.status = STATUS_CRC_ERR;
        end else begin
            push_rec.status = STATUS_OK;
        end
    end

    assign push = accept && last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
            crc_reg   <= CRC_INIT;
            busy_reg  <= 1'b0;
            hum_reg   <= 20'd0;
            temp_reg  <= 20'd0;
        end else begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            busy_reg  <= busy_next;
            hum_reg   <= hum_next;
            temp_reg  <= temp_next;
        end
    end

endmodule

/* hdl/htfd_fifo.sv */
module htfd_fifo #(
    parameter int unsigned DEPTH = htfd_pkg::FIFO_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  htfd_pkg::frame_rec_t push_rec,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output htfd_pkg::frame_rec_t head_rec
);
    import htfd_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    frame_rec_t          mem_reg [DEPTH];
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full       = (cnt_reg == FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* hdl/htfd_back.sv */
module htfd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  htfd_pkg::frame_rec_t head_rec,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [htfd_pkg::TDATA_W-1:0] m_tdata,  // humidity_raw, temperature_raw,
                                                    // humidity_centipercent,
                                                    // temperature_centidegree, zero pad
    output logic [1:0]           m_tuser    // frame_status
);
    import htfd_pkg::*;

    logic               valid_reg;
    logic [1:0]         status_reg;
    logic [19:0]        hum_raw_reg, temp_raw_reg;
    logic [13:0]        hum_cp_reg;
    logic [14:0]        temp_cd_reg;

    logic [33:0]        hum_prod;
    logic [34:0]        temp_prod;
    logic signed [15:0] temp_diff;
    logic               ok;

    assign pop = head_valid && (!valid_reg || m_tready);
    assign ok  = (head_rec.status == STATUS_OK);

    // scale by 10000 / 2^20 and 20000 / 2^20, keep integer part, temp minus 5000
    assign hum_prod  = {14'd0, head_rec.hum_raw} * {20'd0, HUM_SCALE};
    assign temp_prod = {15'd0, head_rec.temp_raw} * {20'd0, TEMP_SCALE};
    assign temp_diff = $signed({1'b0, temp_prod[34:20]}) - TEMP_OFFSET;

    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg   <= head_rec.status;
            hum_raw_reg  <= ok ? head_rec.hum_raw : 20'd0;
            temp_raw_reg <= ok ? head_rec.temp_raw : 20'd0;
            hum_cp_reg   <= ok ? hum_prod[33:20] : 14'd0;
            temp_cd_reg  <= ok ? temp_diff[14:0] : 15'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'd0, temp_cd_reg, hum_cp_reg, temp_raw_reg, hum_raw_reg};

endmodule

/* hdl/humidity_temp_frame_decoder_top.sv */
// humidity and temperature sensor response frame decoder
// input stream: one response byte per request, s_tdata = byte, s_tuser = frame start
// (marks the status byte and restarts the byte count and crc). seven bytes make
// a frame: status, five data bytes, crc. the seventh byte produces one result on
// the output stream: m_tuser = frame status (ok, busy, crc mismatch, not enabled),
// m_tdata = raw humidity and temperature words and the scaled values.
// apb port: register 0 at 0x0 is crc check enable (reset 1), register 1 at 0x4 is
// block enable (reset 0); write only while the stream is idle.
// throughput: one byte per cycle while the queue has room; the crc step is combinational.
// path: once the seventh byte is accepted, the frame is written into the queue; from the
// queue head the scaling multipliers feed the output register, which drives m_tvalid.
// reset clears the partial frame, the queue and the output valid flag, and loads
// the register defaults. when the receiver stalls the output register holds and
// the queue fills; s_tready drops only while the queue is full, so bytes keep
// flowing through up to FIFO_DEPTH completed frames behind a stalled output.
module humidity_temp_frame_decoder_top #(
    parameter int unsigned FIFO_DEPTH = htfd_pkg::FIFO_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [htfd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [htfd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [htfd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // rx_byte
    input  logic [0:0]                        s_tuser,  // frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [htfd_pkg::TDATA_W-1:0]      m_tdata,  // humidity_raw, temperature_raw,
                                                        // humidity_centipercent,
                                                        // temperature_centidegree, zero pad
    output logic [1:0]                        m_tuser   // frame_status
);
    import htfd_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic       reg_idx;
    logic       push, fifo_full, pop, head_valid;
    frame_rec_t push_rec, head_rec;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crc_check_enable <= 1'b1;
            cfg_reg.block_enabled    <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CRC_CHECK: cfg_reg.crc_check_enable <= pwdata[0];
                REG_ENABLE:    cfg_reg.block_enabled    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CRC_CHECK: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_reg.crc_check_enable};
            REG_ENABLE:    prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_reg.block_enabled};
            default:       prdata = '0;
        endcase
    end

    htfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .push_rec  (push_rec)
    );

    htfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_rec   (push_rec),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    htfd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
